// ----- rtl/cfd_pkg.sv -----
package cfd_pkg;

  // frame flag bytes
  localparam logic [7:0] StartFlag  = 8'hF1;
  localparam logic [7:0] StopFlag   = 8'hF2;
  localparam logic [7:0] EscapeFlag = 8'hF3;
  localparam logic [7:0] ExtFlag    = 8'hF0;
  localparam logic [7:0] MaxEscCode = 8'h03;

  // depth of the queue between classifier and decoder
  localparam int unsigned QueueDepth = 2;

  // machine state codes
  localparam logic [3:0] MsError   = 4'd0;
  localparam logic [3:0] MsReady   = 4'd1;
  localparam logic [3:0] MsIdle    = 4'd2;
  localparam logic [3:0] MsHaveId  = 4'd3;
  localparam logic [3:0] MsInUse   = 4'd4;
  localparam logic [3:0] MsPause   = 4'd5;
  localparam logic [3:0] MsFinish  = 4'd6;
  localparam logic [3:0] MsManual  = 4'd7;
  localparam logic [3:0] MsOffline = 4'd8;
  localparam logic [3:0] MsUnknown = 4'd9;

  // raw status nibble codes
  localparam logic [3:0] StError   = 4'h0;
  localparam logic [3:0] StReady   = 4'h1;
  localparam logic [3:0] StIdle    = 4'h2;
  localparam logic [3:0] StHaveId  = 4'h3;
  localparam logic [3:0] StInUse   = 4'h5;
  localparam logic [3:0] StPause   = 4'h6;
  localparam logic [3:0] StFinish  = 4'h7;
  localparam logic [3:0] StManual  = 4'h8;
  localparam logic [3:0] StOffline = 4'h9;

  typedef enum logic [1:0] {
    VerdictOk        = 2'd0,
    VerdictMalformed = 2'd1,
    VerdictBadSum    = 2'd2
  } verdict_e;

  typedef enum logic {
    KindContent = 1'b0,
    KindVerdict = 1'b1
  } kind_e;

  // classified input item
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       is_start;
    logic       is_stop;
    logic       is_escape;
    logic       code_ok;
  } cls_t;

  // result item
  typedef struct packed {
    kind_e      kind;
    logic [7:0] content;
    verdict_e   verdict;
    logic       toggle;
    logic [1:0] prev_status;
    logic [3:0] mstate;
  } res_t;

  // status nibble to machine state code
  function automatic logic [3:0] state_code(input logic [3:0] s);
    logic [3:0] r;
    case (s)
      StError:   r = MsError;
      StReady:   r = MsReady;
      StIdle:    r = MsIdle;
      StHaveId:  r = MsHaveId;
      StInUse:   r = MsInUse;
      StPause:   r = MsPause;
      StFinish:  r = MsFinish;
      StManual:  r = MsManual;
      StOffline: r = MsOffline;
      default:   r = MsUnknown;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/cfd_front.sv -----
module cfd_front (
  input  logic          [7:0] rx_byte_i,
  input  logic                buffer_last_i,
  output cfd_pkg::cls_t       cls_o
);
  import cfd_pkg::*;

  // flag and escape code classification
  always_comb begin
    cls_o.data      = rx_byte_i;
    cls_o.last      = buffer_last_i;
    cls_o.is_start  = (rx_byte_i == StartFlag);
    cls_o.is_stop   = (rx_byte_i == StopFlag);
    cls_o.is_escape = (rx_byte_i == EscapeFlag);
    cls_o.code_ok   = (rx_byte_i <= MaxEscCode);
  end

endmodule

// ----- rtl/cfd_queue.sv -----
module cfd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_i,
  input  cfd_pkg::cls_t wr_data_i,
  output logic          full_o,
  input  logic          rd_i,
  output cfd_pkg::cls_t rd_data_o,
  output logic          empty_o
);
  import cfd_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QueueDepth);

  cls_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_wr, do_rd;

  assign full_o    = (cnt_q == FullCnt);
  assign empty_o   = (cnt_q == '0);
  assign rd_data_o = mem_q[rd_ptr_q];
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

// ----- rtl/cfd_back.sv -----
module cfd_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cfd_pkg::cls_t cls_i,
  input  logic          cls_valid_i,
  output logic          cls_take_o,
  output cfd_pkg::res_t res_o,
  output logic          res_valid_o,
  input  logic          res_pop_i
);
  import cfd_pkg::*;

  logic [1:0] raw_cnt_q, raw_cnt_d;
  logic       esc_q, esc_d;
  logic [7:0] xor_q, xor_d;
  logic [1:0] ucnt_q, ucnt_d;
  logic [7:0] status_q, status_d;
  logic [7:0] held_q, held_d;
  logic       held_vld_q, held_vld_d;
  logic       err_q, err_d;
  logic       out_vld_q, out_vld_d;
  res_t       out_q, out_d;
  logic       take_unstuffed;
  logic [7:0] ubyte;
  logic       ok_shape;

  assign res_o       = out_q;
  assign res_valid_o = out_vld_q;
  // an item is taken whenever the result slot is free or being emptied
  assign cls_take_o  = cls_valid_i && (!out_vld_q || res_pop_i);

  // frame decode and result build
  always_comb begin
    raw_cnt_d      = raw_cnt_q;
    esc_d          = esc_q;
    xor_d          = xor_q;
    ucnt_d         = ucnt_q;
    status_d       = status_q;
    held_d         = held_q;
    held_vld_d     = held_vld_q;
    err_d          = err_q;
    out_vld_d      = out_vld_q && !res_pop_i;
    out_d          = out_q;
    take_unstuffed = 1'b0;
    ubyte          = cls_i.data;
    ok_shape       = (raw_cnt_q == 2'd2) && cls_i.is_stop && !esc_q && !err_q &&
                     (ucnt_q == 2'd2);

    if (cls_take_o) begin
      if (cls_i.last) begin
        // end of buffer: verdict, then clear for the next frame
        out_vld_d         = 1'b1;
        out_d.kind        = KindVerdict;
        out_d.content     = '0;
        out_d.toggle      = 1'b0;
        out_d.prev_status = '0;
        out_d.mstate      = MsUnknown;
        if (!ok_shape) begin
          out_d.verdict = VerdictMalformed;
        end else if (xor_q != '0) begin
          out_d.verdict = VerdictBadSum;
        end else begin
          out_d.verdict     = VerdictOk;
          out_d.toggle      = status_q[7];
          out_d.prev_status = status_q[5:4];
          out_d.mstate      = state_code(status_q[3:0]);
        end
        raw_cnt_d  = '0;
        esc_d      = 1'b0;
        xor_d      = '0;
        ucnt_d     = '0;
        status_d   = '0;
        held_d     = '0;
        held_vld_d = 1'b0;
        err_d      = 1'b0;
      end else if (raw_cnt_q == 2'd0) begin
        // first byte must be the start flag
        raw_cnt_d = 2'd1;
        if (!cls_i.is_start) begin
          err_d = 1'b1;
        end
      end else begin
        raw_cnt_d = 2'd2;
        if (!err_q) begin
          if (esc_q) begin
            esc_d = 1'b0;
            if (!cls_i.code_ok) begin
              err_d = 1'b1;
            end else begin
              ubyte          = ExtFlag | cls_i.data;
              take_unstuffed = 1'b1;
            end
          end else if (cls_i.is_escape) begin
            esc_d = 1'b1;
          end else begin
            take_unstuffed = 1'b1;
          end
        end
      end

      // unstuffed byte: status first, then content with one-byte hold
      if (take_unstuffed) begin
        xor_d = xor_q ^ ubyte;
        if (ucnt_q == 2'd0) begin
          status_d = ubyte;
          ucnt_d   = 2'd1;
        end else begin
          if (held_vld_q) begin
            out_vld_d         = 1'b1;
            out_d.kind        = KindContent;
            out_d.content     = held_q;
            out_d.verdict     = VerdictOk;
            out_d.toggle      = 1'b0;
            out_d.prev_status = '0;
            out_d.mstate      = MsError;
          end
          held_d     = ubyte;
          held_vld_d = 1'b1;
          ucnt_d     = 2'd2;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_cnt_q  <= '0;
      esc_q      <= 1'b0;
      xor_q      <= '0;
      ucnt_q     <= '0;
      status_q   <= '0;
      held_q     <= '0;
      held_vld_q <= 1'b0;
      err_q      <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      raw_cnt_q  <= raw_cnt_d;
      esc_q      <= esc_d;
      xor_q      <= xor_d;
      ucnt_q     <= ucnt_d;
      status_q   <= status_d;
      held_q     <= held_d;
      held_vld_q <= held_vld_d;
      err_q      <= err_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

endmodule

// ----- rtl/csafe_frame_decoder_core.sv -----
// Streaming decoder for a CSAFE standard response frame. Push one raw byte
// per item with buffer_last_i marking the final byte; pop content bytes
// (result_kind 0) as they are unstuffed, delayed by one byte so the checksum
// never appears, and one verdict item (result_kind 1) per buffer carrying
// ok / malformed / checksum mismatch and, when ok, the decoded status byte.
// Content of a frame whose verdict is not ok is still delivered and must be
// discarded by the consumer. Throughput is one byte per clock while the result
// register is free or being popped: a classifier feeds a two-entry queue, and
// the decoder updates its frame state per byte taken and writes results into
// its single-entry result register, which drives the outputs.
module csafe_frame_decoder_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] rx_byte_i,
  input  logic       buffer_last_i,
  output logic       empty,
  input  logic       pop,
  output logic       result_kind_o,
  output logic [7:0] content_byte_o,
  output logic [1:0] verdict_o,
  output logic       frame_toggle_o,
  output logic [1:0] prev_frame_status_o,
  output logic [3:0] machine_state_o
);
  import cfd_pkg::*;

  cls_t cls_in;
  cls_t cls_out;
  logic q_empty;
  logic q_take;
  res_t res;
  logic res_valid;

  // byte classification
  cfd_front u_front (
    .rx_byte_i     (rx_byte_i),
    .buffer_last_i (buffer_last_i),
    .cls_o         (cls_in)
  );

  // decoupling queue
  cfd_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (push),
    .wr_data_i (cls_in),
    .full_o    (full),
    .rd_i      (q_take),
    .rd_data_o (cls_out),
    .empty_o   (q_empty)
  );

  // frame state and results
  cfd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cls_i       (cls_out),
    .cls_valid_i (!q_empty),
    .cls_take_o  (q_take),
    .res_o       (res),
    .res_valid_o (res_valid),
    .res_pop_i   (pop)
  );

  assign empty               = !res_valid;
  assign result_kind_o       = res.kind;
  assign content_byte_o      = res.content;
  assign verdict_o           = res.verdict;
  assign frame_toggle_o      = res.toggle;
  assign prev_frame_status_o = res.prev_status;
  assign machine_state_o     = res.mstate;

endmodule

// ----- sim/csafe_frame_decoder_core_tb.sv -----
`timescale 1ns / 1ps

module csafe_frame_decoder_core_tb;
  import cfd_pkg::*;

  localparam int RandomItems = 2000;
  localparam int HoldCycles  = 150;

  typedef logic [7:0] byte_q_t[$];

  // one expected item on the result side
  typedef struct {
    kind_e      kind;
    logic [7:0] content;
    verdict_e   verdict;
    logic       toggle;
    logic [1:0] prev_status;
    logic [3:0] mstate;
  } frame_result_t;

  // ways a generated frame can be broken
  typedef enum int {
    FlawNone,
    FlawBadStart,
    FlawBadStop,
    FlawBadSum,
    FlawBadEscape,
    FlawEscBeforeStop,
    FlawNoSum,
    FlawTruncated
  } flaw_e;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       push          = 1'b0;
  logic [7:0] rx_byte_i     = '0;
  logic       buffer_last_i = 1'b0;
  logic       pop           = 1'b0;
  logic       full;
  logic       empty;
  logic       result_kind_o;
  logic [7:0] content_byte_o;
  logic [1:0] verdict_o;
  logic       frame_toggle_o;
  logic [1:0] prev_frame_status_o;
  logic [3:0] machine_state_o;

  // decoder state as the testbench tracks it
  logic [1:0] raw_seen     = '0;
  logic       esc_wait     = 1'b0;
  logic [7:0] xor_sum      = '0;
  logic [1:0] body_seen    = '0;
  logic [7:0] status_byte  = '0;
  logic [7:0] delay_byte   = '0;
  logic       delay_full   = 1'b0;
  logic       frame_broken = 1'b0;

  frame_result_t awaited_results[$];
  int mismatches   = 0;
  int bytes_sent   = 0;
  int burst_left   = 0;
  int gap_max      = 2;
  int stall_mode   = 1;
  int hold_left    = 0;
  int rx_cycle     = 0;
  logic hold_request = 1'b0;

  csafe_frame_decoder_core dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .push                (push),
    .full                (full),
    .rx_byte_i           (rx_byte_i),
    .buffer_last_i       (buffer_last_i),
    .empty               (empty),
    .pop                 (pop),
    .result_kind_o       (result_kind_o),
    .content_byte_o      (content_byte_o),
    .verdict_o           (verdict_o),
    .frame_toggle_o      (frame_toggle_o),
    .prev_frame_status_o (prev_frame_status_o),
    .machine_state_o     (machine_state_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  // status nibble to machine state: 0..3 map straight, 5..9 shift down, rest unknown
  function automatic logic [3:0] status_to_state(input logic [3:0] nib);
    if (nib <= 4'd3) return nib;
    if (nib >= 4'd5 && nib <= 4'd9) return nib - 4'd1;
    return MsUnknown;
  endfunction

  // track one accepted byte and queue the results it causes
  task automatic track_frame_byte(input logic [7:0] b, input logic last);
    frame_result_t r;
    logic [7:0] u;
    logic shape_ok;
    if (last) begin
      r.kind        = KindVerdict;
      r.content     = '0;
      r.toggle      = 1'b0;
      r.prev_status = '0;
      shape_ok = raw_seen >= 2 && b == StopFlag && !esc_wait && !frame_broken &&
                 body_seen >= 2;
      if (!shape_ok) begin
        r.verdict = VerdictMalformed;
        r.mstate  = MsUnknown;
      end else if (xor_sum != 8'h00) begin
        r.verdict = VerdictBadSum;
        r.mstate  = MsUnknown;
      end else begin
        r.verdict     = VerdictOk;
        r.toggle      = status_byte[7];
        r.prev_status = status_byte[5:4];
        r.mstate      = status_to_state(status_byte[3:0]);
      end
      awaited_results.insert(awaited_results.size(), r);
      // buffer done, start clean
      raw_seen     = '0;
      esc_wait     = 1'b0;
      xor_sum      = '0;
      body_seen    = '0;
      status_byte  = '0;
      delay_byte   = '0;
      delay_full   = 1'b0;
      frame_broken = 1'b0;
      return;
    end
    // first byte must be the start flag
    if (raw_seen == 0) begin
      raw_seen = 1;
      if (b != StartFlag) frame_broken = 1'b1;
      return;
    end
    if (raw_seen < 2) raw_seen++;
    if (frame_broken) return;
    // unstuffing
    if (esc_wait) begin
      esc_wait = 1'b0;
      if (b > MaxEscCode) begin
        frame_broken = 1'b1;
        return;
      end
      u = ExtFlag | b;
    end else if (b == EscapeFlag) begin
      esc_wait = 1'b1;
      return;
    end else begin
      u = b;
    end
    xor_sum ^= u;
    // status first, then content one byte late
    if (body_seen == 0) begin
      status_byte = u;
      body_seen   = 1;
    end else begin
      if (delay_full) begin
        r.kind        = KindContent;
        r.content     = delay_byte;
        r.verdict     = VerdictOk;
        r.toggle      = 1'b0;
        r.prev_status = '0;
        r.mstate      = '0;
        awaited_results.insert(awaited_results.size(), r);
      end
      delay_byte = u;
      delay_full = 1'b1;
      body_seen  = 2;
    end
  endtask

  // offer one item, with gaps between bursts, and wait until it is taken
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    logic taken;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    push          <= 1'b1;
    rx_byte_i     <= b;
    buffer_last_i <= last;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = !full;
      @(posedge clk_i);
    end
    track_frame_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_raw(input byte_q_t raw);
    foreach (raw[i]) send_byte(raw[i], i == raw.size() - 1);
  endtask

  // wrap a body (status plus content) into a frame, maybe broken, and send it
  task automatic send_frame(input byte_q_t body, input flaw_e flaw);
    byte_q_t raw;
    logic [7:0] sum;
    logic [7:0] x;
    int pos;
    int keep;
    raw = {};
    sum = '0;
    if (flaw == FlawBadStart) begin
      do x = 8'($urandom); while (x == StartFlag);
      raw.insert(raw.size(), x);
    end else begin
      raw.insert(raw.size(), StartFlag);
    end
    foreach (body[i]) sum ^= body[i];
    if (flaw == FlawBadSum) sum ^= 8'($urandom_range(1, 255));
    if (flaw != FlawNoSum) body.insert(body.size(), sum);
    // byte stuffing of the flag range
    foreach (body[i]) begin
      if (body[i] >= ExtFlag && body[i] <= EscapeFlag) begin
        raw.insert(raw.size(), EscapeFlag);
        raw.insert(raw.size(), body[i] & MaxEscCode);
      end else begin
        raw.insert(raw.size(), body[i]);
      end
    end
    if (flaw == FlawBadEscape) begin
      pos = $urandom_range(1, raw.size());
      raw.insert(pos, EscapeFlag);
      raw.insert(pos + 1, 8'($urandom_range(int'(MaxEscCode) + 1, 255)));
    end
    if (flaw == FlawEscBeforeStop) raw.insert(raw.size(), EscapeFlag);
    if (flaw == FlawBadStop) begin
      do x = 8'($urandom); while (x == StopFlag);
      raw.insert(raw.size(), x);
    end else begin
      raw.insert(raw.size(), StopFlag);
    end
    if (flaw == FlawTruncated) begin
      keep = $urandom_range(1, raw.size() - 1);
      while (raw.size() > keep) raw.delete(raw.size() - 1);
    end
    send_raw(raw);
  endtask

  // status byte plus random content, flag bytes favored
  function automatic byte_q_t random_body();
    byte_q_t body;
    int len;
    logic [3:0] nib;
    body = {};
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 8);
    if ($urandom_range(0, 1) == 1) begin
      nib = 4'($urandom_range(0, 8));
      if (nib >= 4'd4) nib++;
      body.insert(body.size(), {1'($urandom), 1'($urandom), 2'($urandom), nib});
    end else begin
      body.insert(body.size(), 8'($urandom));
    end
    repeat (len) begin
      if ($urandom_range(0, 3) == 0) begin
        body.insert(body.size(), ExtFlag | 8'($urandom_range(0, 3)));
      end else begin
        body.insert(body.size(), 8'($urandom));
      end
    end
    return body;
  endfunction

  // arbitrary buffer, heavy on flag bytes
  function automatic byte_q_t random_noise();
    byte_q_t raw;
    int len;
    raw = {};
    len = $urandom_range(1, 10);
    for (int i = 0; i < len; i++) begin
      if (i == 0 && $urandom_range(0, 1) == 1) begin
        raw.insert(raw.size(), StartFlag);
      end else if ($urandom_range(0, 2) == 0) begin
        raw.insert(raw.size(), ExtFlag | 8'($urandom_range(0, 3)));
      end else begin
        raw.insert(raw.size(), 8'($urandom));
      end
    end
    return raw;
  endfunction

  // receiver: long hold on request, else a stall pattern
  always @(posedge clk_i) begin
    if (hold_request) begin
      hold_left    = HoldCycles;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      case (stall_mode)
        0:       pop <= 1'b1;
        1:       pop <= ($urandom_range(0, 3) != 0);
        2:       pop <= ((rx_cycle % 7) < 4);
        default: pop <= ($urandom_range(0, 9) == 0);
      endcase
    end
    rx_cycle++;
  end

  task automatic compare_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // result check: sampled mid-cycle, taken at the next rising edge
  always @(negedge clk_i) begin
    frame_result_t want;
    if (rst_ni && pop && !empty) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result, expected none actual kind %0d content %0h verdict %0d",
                 $time, result_kind_o, content_byte_o, verdict_o);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        compare_field("result_kind", want.kind, result_kind_o);
        compare_field("content_byte", want.content, content_byte_o);
        compare_field("verdict", want.verdict, verdict_o);
        compare_field("frame_toggle", want.toggle, frame_toggle_o);
        compare_field("prev_frame_status", want.prev_status, prev_frame_status_o);
        compare_field("machine_state", want.mstate, machine_state_o);
      end
    end
  end

  // good frame with an escaped byte and the byte extremes
  task automatic test_good_frame();
    byte_q_t body;
    body = {8'h95, 8'hF0, 8'hFF, 8'h00};
    send_frame(body, FlawNone);
  endtask

  task automatic test_bad_start();
    byte_q_t body;
    body = {8'h01};
    send_frame(body, FlawBadStart);
  endtask

  // buffers of one and two bytes
  task automatic test_short_buffers();
    byte_q_t raw;
    raw = {StopFlag};
    send_raw(raw);
    raw = {StartFlag, StopFlag};
    send_raw(raw);
  endtask

  task automatic test_bad_escape();
    byte_q_t body;
    body = {8'h01, 8'h02};
    send_frame(body, FlawBadEscape);
  endtask

  task automatic test_escape_before_stop();
    byte_q_t body;
    body = {8'h01};
    send_frame(body, FlawEscBeforeStop);
  endtask

  // receiver holds off while the sender keeps offering items back to back
  task automatic test_backpressure();
    gap_max    = 0;
    stall_mode = 0;
    hold_request = 1'b1;
    repeat (6) send_frame(random_body(), FlawNone);
  endtask

  // mostly well-formed frames, some broken ones and noise
  task automatic test_random_traffic();
    int stop_at;
    int seg_end;
    int pick;
    flaw_e flaw;
    stop_at = bytes_sent + RandomItems;
    seg_end = bytes_sent;
    while (bytes_sent < stop_at) begin
      if (bytes_sent >= seg_end) begin
        case ($urandom_range(0, 2))
          0:       gap_max = 0;
          1:       gap_max = 3;
          default: gap_max = 10;
        endcase
        stall_mode = $urandom_range(0, 3);
        seg_end = bytes_sent + 150;
      end
      pick = $urandom_range(0, 9);
      if (pick < 2) begin
        send_raw(random_noise());
      end else begin
        case ($urandom_range(0, 19))
          12:      flaw = FlawBadStart;
          13:      flaw = FlawBadStop;
          14:      flaw = FlawBadSum;
          15:      flaw = FlawBadEscape;
          16:      flaw = FlawEscBeforeStop;
          17:      flaw = FlawNoSum;
          18, 19:  flaw = FlawTruncated;
          default: flaw = FlawNone;
        endcase
        send_frame(random_body(), flaw);
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_good_frame();
    test_bad_start();
    test_short_buffers();
    test_bad_escape();
    test_escape_before_stop();
    test_backpressure();
    test_random_traffic();
    push <= 1'b0;
    // drain, then give stray results a chance to show
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
